// ===== design/lrmp_pkg.sv =====
// lrmp_pkg: types, constants and small helpers for the recurrence term engine
// no dependencies; imported by the channel interfaces and every lrmp module
`timescale 1ns / 1ps

package lrmp_pkg;

  localparam int unsigned INDEX_BITS = 31;
  localparam int unsigned VALUE_BITS = 30;

  // modulus and barrett constant floor(2^60 / p)
  localparam logic [VALUE_BITS-1:0] MODULUS = 30'd1000000007;
  localparam logic [63:0] BarrettWide = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BARRETT_M = BarrettWide[30:0];

  // three matrix slots of nine entries each
  localparam int unsigned MAT_ENTRIES = 9;
  localparam int unsigned MEM_DEPTH = 3 * MAT_ENTRIES;
  localparam int unsigned ADDR_BITS = $clog2(MEM_DEPTH);

  // index of the last init write: identity into slot 0, companion into slot 1
  localparam logic [4:0] INIT_LAST = 5'd17;
  // row-sum sequencing: three reads, then the hand-off to the output register
  localparam logic [4:0] SUM_DONE = 5'd4;
  localparam logic [4:0] SUM_LAST_RD = 5'd3;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [1:0] slot_t;
  typedef logic [3:0] mat_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_CHECK,
    S_ISSUE,
    S_WAIT,
    S_SUM
  } state_e;

  // travels with every product through the multiplier pipeline
  typedef struct packed {
    logic     first;  // k == 0, starts a new dot product
    logic     last;   // k == 2, dot product complete
    logic     done;   // last entry of the matrix product
    mat_idx_t dest;   // destination entry inside the slot
  } mul_tag_t;

  function automatic value_t addmod(input value_t a, input value_t b);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, MODULUS}) begin
      s = s - {1'b0, MODULUS};
    end
    return s[VALUE_BITS-1:0];
  endfunction

  function automatic mat_idx_t mat_idx(input logic [1:0] row, input logic [1:0] col);
    return {2'b00, row} * 4'd3 + {2'b00, col};
  endfunction

  function automatic addr_t slot_base(input slot_t s);
    addr_t b;
    case (s)
      2'd0:    b = addr_t'(0);
      2'd1:    b = addr_t'(MAT_ENTRIES);
      2'd2:    b = addr_t'(2 * MAT_ENTRIES);
      default: b = addr_t'(0);
    endcase
    return b;
  endfunction

  // the slot held by neither the accumulator nor the base
  function automatic slot_t free_slot(input slot_t acc, input slot_t base);
    return 2'd3 - acc - base;
  endfunction

  // identity at 0..8, companion [[1,0,1],[1,0,0],[0,1,0]] at 9..17
  function automatic value_t init_word(input logic [4:0] idx);
    value_t w;
    case (idx)
      5'd0, 5'd4, 5'd8:            w = value_t'(1);
      5'd9, 5'd11, 5'd12, 5'd16:   w = value_t'(1);
      default:                     w = '0;
    endcase
    return w;
  endfunction

endpackage

// ===== design/lrmp_index_if.sv =====
// lrmp_index_if: input channel carrying the term index
// depends on lrmp_pkg
`timescale 1ns / 1ps

interface lrmp_index_if;
  import lrmp_pkg::*;

  logic   valid;
  logic   ready;
  index_t term_index;

  modport source (output valid, output term_index, input ready);
  modport sink (input valid, input term_index, output ready);
endinterface

// ===== design/lrmp_value_if.sv =====
// lrmp_value_if: output channel carrying the term value
// depends on lrmp_pkg
`timescale 1ns / 1ps

interface lrmp_value_if;
  import lrmp_pkg::*;

  logic   valid;
  logic   ready;
  value_t term_value;

  modport source (output valid, output term_value, input ready);
  modport sink (input valid, input term_value, output ready);
endinterface

// ===== design/lrmp_mat_ram.sv =====
// lrmp_mat_ram: matrix store, three slots of nine words, one write and two
// registered read ports; depends on lrmp_pkg
`timescale 1ns / 1ps

module lrmp_mat_ram (
  input  logic             clk_i,
  input  logic             we_i,
  input  lrmp_pkg::addr_t  waddr_i,
  input  lrmp_pkg::value_t wdata_i,
  input  lrmp_pkg::addr_t  raddr_a_i,
  input  lrmp_pkg::addr_t  raddr_b_i,
  output lrmp_pkg::value_t rdata_a_o,
  output lrmp_pkg::value_t rdata_b_o
);
  import lrmp_pkg::*;

  value_t mem [MEM_DEPTH];
  value_t rdata_a_q;
  value_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== design/lrmp_mulmod.sv =====
// lrmp_mulmod: pipelined modular multiplier (a * b mod p), barrett reduction,
// six stages, one product per cycle; depends on lrmp_pkg
`timescale 1ns / 1ps

module lrmp_mulmod (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lrmp_pkg::value_t   a_i,
  input  lrmp_pkg::value_t   b_i,
  input  lrmp_pkg::mul_tag_t tag_i,
  output logic               out_valid_o,
  output lrmp_pkg::value_t   r_o,
  output lrmp_pkg::mul_tag_t tag_o
);
  import lrmp_pkg::*;

  localparam int unsigned Stages = 6;

  logic [Stages-1:0] valid_q;
  mul_tag_t          tag_q [Stages];

  logic [59:0] prod1_q;
  logic [31:0] lo2_q;
  logic [30:0] quot2_q;
  logic [31:0] lo3_q;
  logic [31:0] qp3_q;
  logic [31:0] rem4_q;
  logic [31:0] rem5_q;
  value_t      rem6_q;

  logic [61:0] quot_full;
  logic [60:0] qp_full;
  logic [31:0] rem5_d;
  logic [31:0] rem6_d;

  assign quot_full = 62'(prod1_q[59:29]) * 62'(BARRETT_M);
  assign qp_full   = 61'(quot2_q) * 61'(MODULUS);

  // barrett leaves the remainder below 3p, two conditional subtracts finish it
  assign rem5_d = (rem4_q >= 32'(MODULUS)) ? rem4_q - 32'(MODULUS) : rem4_q;
  assign rem6_d = (rem5_q >= 32'(MODULUS)) ? rem5_q - 32'(MODULUS) : rem5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[Stages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    for (int s = 1; s < Stages; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    prod1_q <= 60'(a_i) * 60'(b_i);
    lo2_q   <= prod1_q[31:0];
    quot2_q <= quot_full[61:31];
    lo3_q   <= lo2_q;
    qp3_q   <= qp_full[31:0];
    rem4_q  <= lo3_q - qp3_q;
    rem5_q  <= rem5_d;
    rem6_q  <= rem6_d[VALUE_BITS-1:0];
  end

  assign out_valid_o = valid_q[Stages-1];
  assign r_o         = rem6_q;
  assign tag_o       = tag_q[Stages-1];

endmodule

// ===== design/linear_recurrence_term_by_matrix_power_top.sv =====
// linear_recurrence_term_by_matrix_power_top: sequencer around the matrix store
// and the shared modular multiplier; depends on lrmp_pkg, lrmp_index_if,
// lrmp_value_if, lrmp_mat_ram and lrmp_mulmod
`timescale 1ns / 1ps

// Returns term n mod 1000000007 of a(n) = a(n-1) + a(n-3), a(1..3) = 1, by
// raising the 3x3 companion matrix to the power n-3 with square-and-multiply.
// One query is worked on at a time and the input is not ready meanwhile. Every
// matrix product goes as 27 modular multiplies through one pipelined multiplier
// (one issue per cycle). The hand-off of a result waits until the output register
// is free. The finished value sits in an output register, so the next query is
// taken while it waits to be collected.

module linear_recurrence_term_by_matrix_power_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  lrmp_index_if.sink   index_i,
  lrmp_value_if.source value_o
);
  import lrmp_pkg::*;

  state_e     state_q, state_d;
  index_t     exp_q;
  logic [4:0] cnt_q;
  logic [1:0] i_q, j_q, k_q;
  slot_t      acc_slot_q, base_slot_q;
  logic       op_sq_q;
  value_t     mac_q;
  value_t     sum_q;
  logic       out_valid_q;
  value_t     out_data_q;

  logic       iss_v_q;
  mul_tag_t   iss_tag_q;

  logic       iss_v;
  mul_tag_t   iss_tag;
  logic       mem_we;
  addr_t      mem_waddr;
  value_t     mem_wdata;
  addr_t      raddr_a, raddr_b;
  value_t     rdata_a, rdata_b;

  logic       res_v;
  value_t     res_r;
  mul_tag_t   res_tag;
  value_t     res_val;

  slot_t      lslot, fslot;
  logic       in_ready;
  logic       out_free;
  logic       issue_last;

  assign lslot      = op_sq_q ? base_slot_q : acc_slot_q;
  assign fslot      = free_slot(acc_slot_q, base_slot_q);
  assign out_free   = !out_valid_q || value_o.ready;
  assign issue_last = (i_q == 2'd2) && (j_q == 2'd2) && (k_q == 2'd2);
  assign res_val    = res_tag.first ? res_r : addmod(mac_q, res_r);

  lrmp_mat_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  lrmp_mulmod u_mulmod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (iss_v_q),
    .a_i         (rdata_a),
    .b_i         (rdata_b),
    .tag_i       (iss_tag_q),
    .out_valid_o (res_v),
    .r_o         (res_r),
    .tag_o       (res_tag)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (index_i.valid) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (cnt_q == INIT_LAST) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (exp_q == '0) begin
          state_d = S_SUM;
        end else if (exp_q[0]) begin
          state_d = S_ISSUE;
        end else if (exp_q[INDEX_BITS-1:1] == '0) begin
          state_d = S_SUM;
        end else begin
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (issue_last) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (res_v && res_tag.done) begin
          state_d = S_CHECK;
        end
      end
      S_SUM: begin
        if ((cnt_q == SUM_DONE) && out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    iss_v     = 1'b0;
    iss_tag   = '{first: k_q == 2'd0, last: k_q == 2'd2, done: issue_last,
                  dest: mat_idx(i_q, j_q)};
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = init_word(cnt_q);
    raddr_a   = slot_base(lslot) + addr_t'(mat_idx(i_q, k_q));
    raddr_b   = slot_base(base_slot_q) + addr_t'(mat_idx(k_q, j_q));
    case (state_q)
      S_IDLE:  in_ready = 1'b1;
      S_INIT:  mem_we = 1'b1;
      S_ISSUE: iss_v = 1'b1;
      S_SUM:   raddr_a = slot_base(acc_slot_q) + cnt_q;
      default: ;
    endcase
    // finished dot product goes into the free slot
    if (res_v && res_tag.last) begin
      mem_we    = 1'b1;
      mem_waddr = slot_base(fslot) + addr_t'(res_tag.dest);
      mem_wdata = res_val;
    end
  end

  assign index_i.ready    = in_ready;
  assign value_o.valid    = out_valid_q;
  assign value_o.term_value = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_q       <= '0;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      acc_slot_q  <= 2'd0;
      base_slot_q <= 2'd1;
      op_sq_q     <= 1'b0;
      out_valid_q <= 1'b0;
      iss_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      iss_v_q <= iss_v;
      if ((state_q == S_SUM) && (cnt_q == SUM_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (value_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (index_i.valid) begin
            exp_q       <= (index_i.term_index > index_t'(3)) ?
                           index_i.term_index - index_t'(3) : '0;
            cnt_q       <= '0;
            acc_slot_q  <= 2'd0;
            base_slot_q <= 2'd1;
          end
        end
        S_INIT: begin
          cnt_q <= cnt_q + 5'd1;
        end
        S_CHECK: begin
          i_q   <= '0;
          j_q   <= '0;
          k_q   <= '0;
          cnt_q <= '0;
          if (exp_q != '0) begin
            if (exp_q[0]) begin
              op_sq_q <= 1'b0;
            end else begin
              op_sq_q <= 1'b1;
              exp_q   <= exp_q >> 1;
            end
          end
        end
        S_ISSUE: begin
          k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          if (k_q == 2'd2) begin
            j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
            if (j_q == 2'd2) begin
              i_q <= i_q + 2'd1;
            end
          end
        end
        S_WAIT: begin
          if (res_v && res_tag.done) begin
            if (op_sq_q) begin
              base_slot_q <= fslot;
            end else begin
              acc_slot_q <= fslot;
              exp_q[0]   <= 1'b0;
            end
          end
        end
        S_SUM: begin
          if (cnt_q != SUM_DONE) begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    iss_tag_q <= iss_tag;
    if (res_v) begin
      mac_q <= res_val;
    end
    // row 0 of the accumulator arrives from the registered read port in the cycle after each read
    if (state_q == S_SUM) begin
      if (cnt_q == 5'd1) begin
        sum_q <= rdata_a;
      end else if ((cnt_q != '0) && (cnt_q <= SUM_LAST_RD)) begin
        sum_q <= addmod(sum_q, rdata_a);
      end
      if ((cnt_q == SUM_DONE) && out_free) begin
        out_data_q <= sum_q;
      end
    end
  end

endmodule

// ===== dv/linear_recurrence_term_by_matrix_power_top_test.sv =====
// linear_recurrence_term_by_matrix_power_top_test: checks the term engine against a matrix-power
// predictor, with random idling on both channels; needs lrmp_pkg, lrmp_index_if, lrmp_value_if
// and the design top
`timescale 1ns / 1ps

module linear_recurrence_term_by_matrix_power_top_test;
  import lrmp_pkg::*;

  localparam longint unsigned TERM_MOD = 64'd1000000007;
  localparam int unsigned RANDOM_PER_PHASE = 100;
  localparam int unsigned SETTLE_CYCLES = 2500;

  // 3x3 matrix, entry (i,j) at i*3+j
  typedef bit [8:0][63:0] mat3_t;

  typedef struct {
    index_t term_index;
    value_t term_value;
  } term_entry_t;

  class term_scoreboard;
    term_entry_t expected_terms[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    static function mat3_t mat_product(mat3_t l, mat3_t r);
      mat3_t p;
      bit [63:0] acc;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) begin
            acc += (l[i*3+k] * r[k*3+j]) % TERM_MOD;
          end
          p[i*3+j] = acc % TERM_MOD;
        end
      end
      return p;
    endfunction

    // square-and-multiply on the companion matrix, then the first row sum
    static function value_t recurrence_term(index_t n);
      mat3_t power;
      mat3_t base;
      bit [63:0] left;
      bit [63:0] sum;
      power = '0;
      power[0] = 1;
      power[4] = 1;
      power[8] = 1;
      base = '0;
      base[0] = 1;
      base[2] = 1;
      base[3] = 1;
      base[7] = 1;
      left = (n > 3) ? (64'(n) - 64'd3) : 64'd0;
      while (left != 0) begin
        if (left[0]) begin
          power = mat_product(power, base);
        end
        left = left >> 1;
        base = mat_product(base, base);
      end
      sum = (power[0] + power[1] + power[2]) % TERM_MOD;
      return value_t'(sum);
    endfunction

    function void note_index(index_t n);
      term_entry_t e;
      e.term_index = n;
      e.term_value = recurrence_term(n);
      expected_terms.push_back(e);
    endfunction

    function void check_value(value_t v);
      term_entry_t e;
      if (expected_terms.size() == 0) begin
        $error("term_value %0d arrived with no query outstanding", v);
        errors++;
      end else begin
        e = expected_terms.pop_front();
        if (v !== e.term_value) begin
          $error("term_value mismatch for index %0d: expected %0d, actual %0d",
                 e.term_index, e.term_value, v);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_terms.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lrmp_index_if index_ch ();
  lrmp_value_if value_ch ();

  linear_recurrence_term_by_matrix_power_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .index_i (index_ch),
    .value_o (value_ch)
  );

  term_scoreboard sb;
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;

  initial begin
    clk_i = 1'b0;
  end

  always #6 clk_i = ~clk_i;

  // result side: random backpressure, every transaction checked
  always @(posedge clk_i) begin
    if (rst_ni && value_ch.valid && value_ch.ready) begin
      sb.check_value(value_ch.term_value);
    end
    value_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  task automatic send_index(input index_t n);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      index_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    index_ch.valid <= 1'b1;
    index_ch.term_index <= n;
    @(posedge clk_i);
    while (!index_ch.ready) begin
      @(posedge clk_i);
    end
    sb.note_index(n);
  endtask

  // hold the input off until every outstanding term has been collected
  task automatic drain_terms();
    index_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // short and mid-sized exponents, a few full-width
  function automatic index_t random_index();
    int unsigned sel;
    int unsigned len;
    index_t v;
    sel = $urandom_range(99);
    if (sel < 40) begin
      v = index_t'($urandom_range(40));
    end else if (sel < 85) begin
      len = $urandom_range(22, 3);
      v = index_t'($urandom) & ((index_t'(1) << len) - index_t'(1));
      v = v | (index_t'(1) << (len - 1));
    end else begin
      v = index_t'($urandom);
    end
    return v;
  endfunction

  initial begin
    index_t directed[$];
    sb = new();
    src_idle_pct = 16;
    sink_idle_pct = 62;
    rst_ni = 1'b0;
    index_ch.valid = 1'b0;
    index_ch.term_index = '0;
    value_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity cases, first powers, extremes and alternating bit patterns
    directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd7, 31'd8, 31'd9,
                 31'd10, 31'h7FFFFFFF, 31'h7FFFFFFE, 31'h40000000, 31'h40000002,
                 31'h40000003, 31'h55555555, 31'h2AAAAAAA, 31'd1000000010};

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 16;
          sink_idle_pct = 62;
        end
        1: begin
          src_idle_pct = 62;
          sink_idle_pct = 16;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (ph == 0) begin
        foreach (directed[i]) begin
          send_index(directed[i]);
        end
        drain_terms();
      end
      repeat (RANDOM_PER_PHASE) begin
        send_index(random_index());
      end
      drain_terms();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #36_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
